// ===== rtl/chained_xor_packet_codec_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the chained XOR packet codec
// Expect clk and rst_n in the scope of use.
// ----------------------------------------------------------------------------
`ifndef CHAINED_XOR_PACKET_CODEC_DEFINES_SVH
`define CHAINED_XOR_PACKET_CODEC_DEFINES_SVH

// Same-cycle implication, off during reset
`define CXP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off during reset
`define CXP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/cxp_pkg.sv =====
// ----------------------------------------------------------------------------
// cxp_pkg
// Types and constants of the chained XOR packet codec.
// ----------------------------------------------------------------------------
`default_nettype none

package cxp_pkg;

    localparam int unsigned HEADER_BYTES = 5;
    localparam logic [7:0]  POS_START    = 8'(HEADER_BYTES);
    localparam logic [7:0]  PAD_INC      = 8'd1;
    localparam logic [7:0]  POS_BIAS     = 8'd3;

    typedef enum logic
    {
        CFG_FIXED_KEY   = 1'b0,
        CFG_DECODE_MODE = 1'b1
    } cfg_index_t;

    localparam int unsigned CFG_DATA_W = 8;

    typedef struct packed
    {
        logic       first;
        logic       last;
        logic [7:0] data_byte;
        logic [7:0] random_key;
        logic [7:0] header_check;
    } in_item_t;

    typedef struct packed
    {
        logic [7:0] out_byte;
        logic       is_header;
        logic       end_of_packet;
        logic       check_ok;
    } out_item_t;

endpackage

`default_nettype wire

// ===== rtl/cxp_in_if.sv =====
// ----------------------------------------------------------------------------
// cxp_in_if
// Input channel: valid/ready handshake carrying one codec input item.
// ----------------------------------------------------------------------------
`default_nettype none

interface cxp_in_if import cxp_pkg::*;;
    logic     valid;
    logic     ready;
    in_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/cxp_out_if.sv =====
// ----------------------------------------------------------------------------
// cxp_out_if
// Output channel: valid/ready handshake carrying one codec result item.
// ----------------------------------------------------------------------------
`default_nettype none

interface cxp_out_if import cxp_pkg::*;;
    logic      valid;
    logic      ready;
    out_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/chained_xor_packet_codec.sv =====
// Result: registered; a result is valid the cycle after its input transfer.
// Throughput: one item per cycle while output ready holds; the chain state
//   is updated in the transfer cycle, so the next byte can follow immediately.
// Stalls: the single result register frees up when it is taken, so input
//   ready follows output ready combinationally while a result is held.
// Reset: asynchronous, active low; chain state, config registers and valid cleared.
// ----------------------------------------------------------------------------
// chained_xor_packet_codec
// Byte-stream packet codec with a two-layer chained XOR and a decode checksum.
// ----------------------------------------------------------------------------
`default_nettype none

`include "chained_xor_packet_codec_defines.svh"

module chained_xor_packet_codec
    import cxp_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    cxp_in_if.sink                     in_ch,
    cxp_out_if.source                  out_ch,
    input  wire logic                  cfg_we,
    input  wire cfg_index_t            cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    // Configuration registers
    logic [7:0] fixed_key_reg;
    logic       decode_mode_reg;

    // Chain state
    logic [7:0] position_reg,     position_next;
    logic [7:0] plain_chain_reg,  plain_chain_next;
    logic [7:0] cipher_chain_reg, cipher_chain_next;
    logic [7:0] payload_sum_reg,  payload_sum_next;
    logic [7:0] expected_sum_reg, expected_sum_next;
    logic [7:0] packet_rand_reg,  packet_rand_next;

    // Result register
    logic      out_valid_reg;
    out_item_t out_item_reg, out_item_next;

    logic     in_xfer;
    in_item_t item;

    // Header pads and per-byte keystreams
    logic [7:0] outer_pad;
    logic [7:0] inner_pad;
    logic [7:0] pos_off;
    logic [7:0] outer_ks;   // fixed key layer
    logic [7:0] inner_ks;   // random key layer
    logic [7:0] stage1;
    logic [7:0] stage2;

    // ------------------------------------------------------------------------
    // Handshake: the result register can take a new item when empty or when
    // its current content is taken in this cycle.
    // ------------------------------------------------------------------------
    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign in_xfer     = in_ch.valid && in_ch.ready;
    assign item        = in_ch.payload;

    assign out_ch.valid   = out_valid_reg;
    assign out_ch.payload = out_item_reg;

    // ------------------------------------------------------------------------
    // Configuration writes
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fixed_key_reg   <= '0;
            decode_mode_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FIXED_KEY:   fixed_key_reg   <= cfg_data[7:0];
                CFG_DECODE_MODE: decode_mode_reg <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Codec datapath. Both keystreams depend only on state, so each layer is
    // one three-input add and an XOR; the decode sum adds one more add and a
    // compare.
    // ------------------------------------------------------------------------
    assign outer_pad = fixed_key_reg + PAD_INC;
    assign inner_pad = item.random_key + PAD_INC;
    assign pos_off   = position_reg - POS_BIAS;
    assign outer_ks  = fixed_key_reg + cipher_chain_reg + pos_off;
    assign inner_ks  = packet_rand_reg + plain_chain_reg + pos_off;

    // Decode strips the outer layer first, encode applies the inner first
    assign stage1 = item.data_byte ^ (decode_mode_reg ? outer_ks : inner_ks);
    assign stage2 = stage1 ^ (decode_mode_reg ? inner_ks : outer_ks);

    always_comb
    begin
        position_next     = position_reg;
        plain_chain_next  = plain_chain_reg;
        cipher_chain_next = cipher_chain_reg;
        payload_sum_next  = payload_sum_reg;
        expected_sum_next = expected_sum_reg;
        packet_rand_next  = packet_rand_reg;

        out_item_next.out_byte      = stage2;
        out_item_next.is_header     = item.first;
        out_item_next.end_of_packet = item.last;
        out_item_next.check_ok      = 1'b0;

        if (item.first)
        begin
            // Header: restart the chains from the checksum byte
            packet_rand_next = item.random_key;
            position_next    = POS_START;
            payload_sum_next = '0;
            if (decode_mode_reg)
            begin
                cipher_chain_next = item.header_check;
                plain_chain_next  = item.header_check ^ outer_pad;
                expected_sum_next = item.header_check ^ outer_pad ^ inner_pad;
                out_item_next.out_byte = expected_sum_next;
                // empty packet: sum is zero
                out_item_next.check_ok = item.last && (expected_sum_next == 8'd0);
            end
            else
            begin
                expected_sum_next = item.header_check;
                plain_chain_next  = item.header_check ^ inner_pad;
                cipher_chain_next = item.header_check ^ inner_pad ^ outer_pad;
                out_item_next.out_byte = cipher_chain_next;
            end
        end
        else
        begin
            position_next    = position_reg + 8'd1;
            plain_chain_next = stage1;
            if (decode_mode_reg)
            begin
                cipher_chain_next      = item.data_byte;
                payload_sum_next       = payload_sum_reg + stage2;
                out_item_next.check_ok = item.last && (payload_sum_next == expected_sum_reg);
            end
            else
            begin
                cipher_chain_next = stage2;
            end
        end
    end

    // ------------------------------------------------------------------------
    // State and result registers
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg     <= '0;
            plain_chain_reg  <= '0;
            cipher_chain_reg <= '0;
            payload_sum_reg  <= '0;
            expected_sum_reg <= '0;
            packet_rand_reg  <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (in_xfer)
            begin
                position_reg     <= position_next;
                plain_chain_reg  <= plain_chain_next;
                cipher_chain_reg <= cipher_chain_next;
                payload_sum_reg  <= payload_sum_next;
                expected_sum_reg <= expected_sum_next;
                packet_rand_reg  <= packet_rand_next;
                out_valid_reg    <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload register, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            out_item_reg <= out_item_next;
        end
    end

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    `CXP_ASSERT_NEXT(a_xfer_gives_result, in_xfer, out_valid_reg,
                     "input transfer did not load the result register")
    `CXP_ASSERT_NOW(a_check_ok_scope, out_valid_reg && out_item_reg.check_ok,
                    out_item_reg.end_of_packet && decode_mode_reg,
                    "check_ok raised outside a decoded last item")
    `CXP_ASSERT_NEXT(a_header_pos, in_xfer && item.first, position_reg == POS_START,
                     "header did not restart the byte position")
    `CXP_ASSERT_NEXT(a_payload_pos, in_xfer && !item.first,
                     position_reg == $past(position_reg) + 8'd1,
                     "payload byte did not advance the position")

endmodule

`default_nettype wire
